// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/oale_pkg.sv =====
// ----------------------------------------------------------------------------
// oale_pkg
// Types, codes and defaults shared by the ordered list engine.
// ----------------------------------------------------------------------------
package oale_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int CMD_W   = 4;
  localparam int POS_W   = 4;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT_AT    = 4'd0,
    CMD_INSERT_FRONT = 4'd1,
    CMD_INSERT_END   = 4'd2,
    CMD_REMOVE_END   = 4'd3,
    CMD_REMOVE_FRONT = 4'd4,
    CMD_REMOVE_AT    = 4'd5,
    CMD_REMOVE_VALUE = 4'd6,
    CMD_SEARCH       = 4'd7,
    CMD_READ         = 4'd8,
    CMD_WRITE        = 4'd9
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADIDX   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word;
  } list_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [WORD_W-1:0]  read_word;
    logic [COUNT_W-1:0] count;
  } list_out_t;

  // index register update
  typedef enum logic [2:0] {
    IDX_HOLD, IDX_CNT, IDX_POS, IDX_ZERO, IDX_CNT_M1, IDX_DEC, IDX_INC
  } idx_op_e;

  // insert target update
  typedef enum logic [1:0] {
    TGT_HOLD, TGT_POS, TGT_ZERO, TGT_CNT
  } tgt_op_e;

  // memory read address
  typedef enum logic [1:0] {
    RD_POS, RD_IDX, RD_IDX_M1, RD_IDX_P1
  } rd_sel_e;

  // memory write address / data
  typedef enum logic [1:0] {
    WR_SHIFT, WR_PUT, WR_SLOT
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_INC, CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic    load;
    idx_op_e idx_op;
    tgt_op_e tgt_op;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    cnt_op_e cnt_op;
    logic    set_status;
    status_e status_code;
    logic    set_found;
    logic    cap_read;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             pos_gt_cnt;
    logic             pos_ge_cnt;
    logic             idx_gt_tgt;
    logic             idx_last;
    logic             idx_zero;
    logic             match;
  } stat_t;

endpackage

// ===== design/oale_dpath.sv =====
// ----------------------------------------------------------------------------
// oale_dpath
// Slot memory, count, walk index, insert target and result registers.
// ----------------------------------------------------------------------------
module oale_dpath #(
  parameter int DEPTH     = oale_pkg::DEPTH_DEF,
  parameter int WORD_BITS = oale_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  oale_pkg::ctrl_t     ctrl,
  input  oale_pkg::list_in_t  request,
  output oale_pkg::stat_t     stat,
  output oale_pkg::list_out_t result
);
  import oale_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PW  = (CW > POS_W) ? CW : POS_W;
  localparam int XW  = (WORD_BITS > WORD_W) ? WORD_BITS : WORD_W;
  localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [WORD_BITS-1:0] mem [DEPTH];

  logic [CMD_W-1:0]     cmd_q;
  logic [POS_W-1:0]     pos_q;
  logic [WORD_BITS-1:0] word_q;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        cnt_next;
  logic [AW-1:0]        idx;
  logic [AW-1:0]        idx_next;
  logic [AW-1:0]        tgt;
  logic [AW-1:0]        tgt_next;
  logic [WORD_BITS-1:0] rdata;
  status_e              status_q;
  logic                 found_q;
  logic [WORD_W-1:0]    read_q;

  logic [XW-1:0]        word_in_x;
  logic [XW-1:0]        rdata_x;
  logic [PW-1:0]        pos_x;
  logic [PW-1:0]        cnt_px;
  logic [AW-1:0]        pos_a;
  logic [CW-1:0]        cnt_m1;
  logic [CW-1:0]        idx_p1;
  logic [AW-1:0]        idx_m1;
  logic [CXW-1:0]       cnt_out;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;

  assign word_in_x = XW'(request.word);
  assign rdata_x   = XW'(rdata);
  assign pos_x     = PW'(pos_q);
  assign cnt_px    = PW'(cnt);
  assign pos_a     = pos_x[AW-1:0];
  assign cnt_m1    = cnt - CW'(1);
  assign idx_p1    = CW'(idx) + CW'(1);
  assign idx_m1    = idx - AW'(1);
  assign cnt_out   = CXW'(cnt);

  always_comb begin
    case (ctrl.rd_sel)
      RD_POS:    raddr = pos_a;
      RD_IDX:    raddr = idx;
      RD_IDX_M1: raddr = idx_m1;
      RD_IDX_P1: raddr = idx_p1[AW-1:0];
      default:   raddr = idx;
    endcase
  end

  always_comb begin
    case (ctrl.wr_sel)
      WR_SHIFT: begin
        waddr = idx;
        wdata = rdata;
      end
      WR_PUT: begin
        waddr = tgt;
        wdata = word_q;
      end
      WR_SLOT: begin
        waddr = pos_a;
        wdata = word_q;
      end
      default: begin
        waddr = idx;
        wdata = word_q;
      end
    endcase
  end

  // slot store with one write port and one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    case (ctrl.idx_op)
      IDX_CNT:    idx_next = cnt[AW-1:0];
      IDX_POS:    idx_next = pos_a;
      IDX_ZERO:   idx_next = '0;
      IDX_CNT_M1: idx_next = cnt_m1[AW-1:0];
      IDX_DEC:    idx_next = idx_m1;
      IDX_INC:    idx_next = idx_p1[AW-1:0];
      default:    idx_next = idx;
    endcase
  end

  always_comb begin
    case (ctrl.tgt_op)
      TGT_POS:  tgt_next = pos_a;
      TGT_ZERO: tgt_next = '0;
      TGT_CNT:  tgt_next = cnt[AW-1:0];
      default:  tgt_next = tgt;
    endcase
  end

  always_comb begin
    case (ctrl.cnt_op)
      CNT_INC: cnt_next = cnt + CW'(1);
      CNT_DEC: cnt_next = cnt_m1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    tgt <= tgt_next;
    if (ctrl.load) begin
      cmd_q    <= request.cmd;
      pos_q    <= request.position;
      word_q   <= word_in_x[WORD_BITS-1:0];
      status_q <= ST_OK;
      found_q  <= 1'b0;
      read_q   <= '0;
    end else begin
      if (ctrl.set_status) begin
        status_q <= ctrl.status_code;
      end
      if (ctrl.set_found) begin
        found_q <= 1'b1;
      end
      if (ctrl.cap_read) begin
        read_q <= rdata_x[WORD_W-1:0];
      end
    end
  end

  assign stat.cmd        = cmd_q;
  assign stat.full       = (cnt == CW'(DEPTH));
  assign stat.empty      = (cnt == '0);
  assign stat.pos_gt_cnt = (pos_x > cnt_px);
  assign stat.pos_ge_cnt = (pos_x >= cnt_px);
  assign stat.idx_gt_tgt = (idx > tgt);
  assign stat.idx_last   = (idx_p1 >= cnt);
  assign stat.idx_zero   = (idx == '0);
  assign stat.match      = (rdata == word_q);

  assign result.status    = status_q;
  assign result.found     = found_q;
  assign result.read_word = read_q;
  assign result.count     = cnt_out[COUNT_W-1:0];

endmodule

// ===== design/oale_ctrl.sv =====
// ----------------------------------------------------------------------------
// oale_ctrl
// Command sequencer: checks, slot shifting walks and value scans.
// ----------------------------------------------------------------------------
module oale_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  oale_pkg::stat_t stat,
  output oale_pkg::ctrl_t ctrl,
  output logic            busy,
  output logic            done
);
  import oale_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_CHECK  = 10'b00_0000_0010,
    S_UP     = 10'b00_0000_0100,
    S_UP_WR  = 10'b00_0000_1000,
    S_DN     = 10'b00_0001_0000,
    S_DN_WR  = 10'b00_0010_0000,
    S_SC_RD  = 10'b00_0100_0000,
    S_SC_CMP = 10'b00_1000_0000,
    S_RD_CAP = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctrl             = '0;
    ctrl.idx_op      = IDX_HOLD;
    ctrl.tgt_op      = TGT_HOLD;
    ctrl.rd_sel      = RD_IDX;
    ctrl.wr_sel      = WR_SHIFT;
    ctrl.cnt_op      = CNT_HOLD;
    ctrl.status_code = ST_OK;
    state_next       = state;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = S_CHECK;
        end
      end

      S_CHECK: begin
        ctrl.rd_sel = RD_POS;
        state_next  = S_DONE;
        unique case (stat.cmd) inside
          CMD_INSERT_AT: begin
            if (stat.full) begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = ST_FULL;
            end else if (stat.pos_gt_cnt) begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = ST_BADIDX;
            end else begin
              ctrl.idx_op = IDX_CNT;
              ctrl.tgt_op = TGT_POS;
              state_next  = S_UP;
            end
          end
          CMD_INSERT_FRONT, CMD_INSERT_END: begin
            if (stat.full) begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = ST_FULL;
            end else begin
              ctrl.idx_op = IDX_CNT;
              ctrl.tgt_op = (stat.cmd == CMD_INSERT_FRONT) ? TGT_ZERO : TGT_CNT;
              state_next  = S_UP;
            end
          end
          CMD_REMOVE_END: begin
            if (stat.empty) begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = ST_EMPTY;
            end else begin
              ctrl.cnt_op = CNT_DEC;
            end
          end
          CMD_REMOVE_FRONT: begin
            if (stat.empty) begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = ST_EMPTY;
            end else begin
              ctrl.idx_op = IDX_ZERO;
              state_next  = S_DN;
            end
          end
          CMD_REMOVE_AT: begin
            if (stat.empty) begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = ST_EMPTY;
            end else if (stat.pos_ge_cnt) begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = ST_BADIDX;
            end else begin
              ctrl.idx_op = IDX_POS;
              state_next  = S_DN;
            end
          end
          CMD_REMOVE_VALUE, CMD_SEARCH: begin
            if (stat.empty) begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = (stat.cmd == CMD_SEARCH) ? ST_NOTFOUND : ST_EMPTY;
            end else begin
              ctrl.idx_op = IDX_CNT_M1;
              state_next  = S_SC_RD;
            end
          end
          CMD_READ: begin
            if (stat.pos_ge_cnt) begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = ST_BADIDX;
            end else begin
              state_next = S_RD_CAP;
            end
          end
          CMD_WRITE: begin
            if (stat.pos_ge_cnt) begin
              ctrl.set_status  = 1'b1;
              ctrl.status_code = ST_BADIDX;
            end else begin
              ctrl.wr_en  = 1'b1;
              ctrl.wr_sel = WR_SLOT;
            end
          end
          default: begin
          end
        endcase
      end

      // open a gap: walk down from count to the target
      S_UP: begin
        ctrl.rd_sel = RD_IDX_M1;
        if (stat.idx_gt_tgt) begin
          state_next = S_UP_WR;
        end else begin
          ctrl.wr_en  = 1'b1;
          ctrl.wr_sel = WR_PUT;
          ctrl.cnt_op = CNT_INC;
          state_next  = S_DONE;
        end
      end

      S_UP_WR: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_sel = WR_SHIFT;
        ctrl.idx_op = IDX_DEC;
        state_next  = S_UP;
      end

      // close a gap: walk up from the removed slot
      S_DN: begin
        ctrl.rd_sel = RD_IDX_P1;
        if (stat.idx_last) begin
          ctrl.cnt_op = CNT_DEC;
          state_next  = S_DONE;
        end else begin
          state_next = S_DN_WR;
        end
      end

      S_DN_WR: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_sel = WR_SHIFT;
        ctrl.idx_op = IDX_INC;
        state_next  = S_DN;
      end

      // scan from the top so the first hit is the last match
      S_SC_RD: begin
        ctrl.rd_sel = RD_IDX;
        state_next  = S_SC_CMP;
      end

      S_SC_CMP: begin
        if (stat.match) begin
          ctrl.set_found = 1'b1;
          state_next     = (stat.cmd == CMD_SEARCH) ? S_DONE : S_DN;
        end else if (stat.idx_zero) begin
          ctrl.set_status  = 1'b1;
          ctrl.status_code = ST_NOTFOUND;
          state_next       = S_DONE;
        end else begin
          ctrl.idx_op = IDX_DEC;
          state_next  = S_SC_RD;
        end
      end

      S_RD_CAP: begin
        ctrl.cap_read = 1'b1;
        state_next    = S_DONE;
      end

      S_DONE: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ===== design/ordered_array_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_array_list_engine_unit
// Packed list of up to DEPTH words with insert, remove, search, read, write.
// ----------------------------------------------------------------------------
// A command beat is taken on a clock edge with start high and busy low; busy
// then stays high until the result beat has gone out. The result beat shows
// on result for one cycle with done high and cannot be held off, so capture
// it on that edge. Every command gives exactly one result beat. Entries live
// in a slot memory with one write port and one registered read port, and
// every moved entry costs a read and a write, so the command time depends on
// how many entries move or are scanned. The next command can be taken once
// busy is low again. The slot memory has no reset and needs no clearing pass:
// only slots below count are ever used, and each of them has been written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_array_list_engine_unit #(
  parameter int DEPTH     = oale_pkg::DEPTH_DEF,
  parameter int WORD_BITS = oale_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  oale_pkg::list_in_t  request,
  output logic                done,
  output oale_pkg::list_out_t result
);
  import oale_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // sequencer: decides each step from the datapath flags
  oale_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  // slot memory, count, walk pointers and result registers
  oale_dpath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .request (request),
    .stat    (stat),
    .result  (result)
  );

  // an accepted beat keeps the unit busy on the next cycle
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accept without busy")
  // results come only while a command is in flight
  `ASSERT_IMPL(a_done_busy, clk, rst, done, busy, "result beat while idle")
  // one result beat per command
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result beat repeated")
  // a match is always reported as ok
  `ASSERT_IMPL(a_found_ok, clk, rst, done && result.found, result.status == ST_OK,
    "found with bad status")

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered list engine. A short directed table
// covers empty, full and bad-index cases first. Random commands follow,
// mostly well-formed for the current fill level. Every result beat is
// compared field by field against a hand-written result or a shadow model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oale_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int RANDOM_BEATS = 560;       // per sender idle phase, three phases
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 1_000_000;

  // code the engine treats as a no-op
  localparam logic [CMD_W-1:0] CMD_SPARE = 4'd15;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  list_in_t  request;
  logic      done;
  list_out_t result;

  ordered_array_list_engine_unit dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Shadow list: contents, fill level and the results still owed by the DUT.
  // Entries at or above list_len are stale and never read.
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] list_words [LIST_DEPTH];
  int                list_len;
  list_out_t         owed_results [$];
  int                mismatches;
  bit                growing;      // random stimulus leans toward inserts

  // make room at slot 'at' and drop the word in
  function automatic void open_slot(int at, logic [WORD_W-1:0] w);
    int i;
    for (i = list_len; i > at; i--) list_words[i] = list_words[i-1];
    list_words[at] = w;
    list_len++;
  endfunction

  // close the hole left by slot 'at'
  function automatic void close_slot(int at);
    int i;
    for (i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
    list_len--;
  endfunction

  // Carry out one command on the shadow list, return the result it owes.
  function automatic list_out_t apply_list_cmd(list_in_t c);
    list_out_t r;
    int        hit;
    int        i;
    r        = '0;
    r.status = ST_OK;
    hit      = -1;
    case (c.cmd)
      CMD_INSERT_AT: begin
        // full is checked before the index
        if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else if (int'(c.position) > list_len) r.status = ST_BADIDX;
        else open_slot(int'(c.position), c.word);
      end
      CMD_INSERT_FRONT: begin
        if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else open_slot(0, c.word);
      end
      CMD_INSERT_END: begin
        if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else open_slot(list_len, c.word);
      end
      CMD_REMOVE_END: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else list_len--;
      end
      CMD_REMOVE_FRONT: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else close_slot(0);
      end
      CMD_REMOVE_AT: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else if (int'(c.position) >= list_len) r.status = ST_BADIDX;
        else close_slot(int'(c.position));
      end
      CMD_REMOVE_VALUE: begin
        // the last matching entry goes
        if (list_len == 0) r.status = ST_EMPTY;
        else begin
          for (i = 0; i < list_len; i++) if (list_words[i] == c.word) hit = i;
          if (hit >= 0) begin
            r.found = 1'b1;
            close_slot(hit);
          end else r.status = ST_NOTFOUND;
        end
      end
      CMD_SEARCH: begin
        for (i = 0; i < list_len; i++) if (list_words[i] == c.word) hit = i;
        if (hit >= 0) r.found = 1'b1;
        else r.status = ST_NOTFOUND;
      end
      CMD_READ: begin
        if (int'(c.position) >= list_len) r.status = ST_BADIDX;
        else r.read_word = list_words[c.position];
      end
      CMD_WRITE: begin
        if (int'(c.position) >= list_len) r.status = ST_BADIDX;
        else list_words[c.position] = c.word;
      end
      default: ;  // spare codes: no-op, status ok
    endcase
    r.count = COUNT_W'(list_len);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table. 'typed' rows carry a hand-written result; the rest are
  // checked against the shadow list. 'reps' issues a row that many times.
  // --------------------------------------------------------------------------
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word;
    int                reps;
    bit                typed;
    list_out_t         want;
  } stim_row_t;

  stim_row_t stim_rows [$];

  task automatic add_row(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
                         logic [WORD_W-1:0] w, int reps, bit typed,
                         status_e st, logic fnd, logic [WORD_W-1:0] rd,
                         logic [COUNT_W-1:0] n);
    stim_row_t row;
    row.cmd            = c;
    row.position       = p;
    row.word           = w;
    row.reps           = reps;
    row.typed          = typed;
    row.want.status    = st;
    row.want.found     = fnd;
    row.want.read_word = rd;
    row.want.count     = n;
    stim_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Random command, shaped by the current fill level so the list sweeps
  // between empty and full. A few beats are pure noise.
  // --------------------------------------------------------------------------
  function automatic list_in_t pick_random_cmd();
    list_in_t it;
    int       roll;
    bit       ins;
    roll        = $urandom_range(99);
    it.cmd      = CMD_SEARCH;
    it.position = POS_W'($urandom_range(15));
    // small value pool gives duplicates for remove_value/search
    it.word     = ($urandom_range(1) == 1) ? WORD_W'($urandom_range(7)) : $urandom;

    if (list_len == LIST_DEPTH) growing = 1'b0;
    else if (list_len == 0) growing = 1'b1;
    else if ($urandom_range(49) == 0) growing = ~growing;

    if (roll < 8) begin
      it.cmd = CMD_W'($urandom_range(15));
    end else if (roll < 70) begin
      ins = growing ? ($urandom_range(99) < 70) : ($urandom_range(99) < 30);
      if (ins) begin
        case ($urandom_range(2))
          0: begin
            it.cmd = CMD_INSERT_AT;
            if (list_len < LIST_DEPTH) it.position = POS_W'($urandom_range(list_len));
          end
          1: it.cmd = CMD_INSERT_FRONT;
          default: it.cmd = CMD_INSERT_END;
        endcase
      end else begin
        case ($urandom_range(3))
          0: it.cmd = CMD_REMOVE_END;
          1: it.cmd = CMD_REMOVE_FRONT;
          2: begin
            it.cmd = CMD_REMOVE_AT;
            if (list_len > 0) it.position = POS_W'($urandom_range(list_len - 1));
          end
          default: begin
            it.cmd = CMD_REMOVE_VALUE;
            if (list_len > 0 && $urandom_range(3) != 0)
              it.word = list_words[$urandom_range(list_len - 1)];
          end
        endcase
      end
    end else begin
      case ($urandom_range(2))
        0: begin
          it.cmd = CMD_SEARCH;
          if (list_len > 0 && $urandom_range(3) != 0)
            it.word = list_words[$urandom_range(list_len - 1)];
        end
        1: it.cmd = CMD_READ;
        default: it.cmd = CMD_WRITE;
      endcase
      if (it.cmd != CMD_SEARCH && list_len > 0 && $urandom_range(6) != 0)
        it.position = POS_W'($urandom_range(list_len - 1));
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Command beat. Drive on the falling edge, optionally idle first for a
  // random stretch, then hold start until a rising edge sees busy low.
  // start stays high between back-to-back beats (one assignment per step).
  // --------------------------------------------------------------------------
  task automatic issue(list_in_t it, int idle_pct, bit typed, list_out_t want);
    list_out_t modeled;
    int        gap;
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    request <= it;
    do @(posedge clk); while (busy);
    // beat taken on this edge: update the shadow list now
    modeled = apply_list_cmd(it);
    owed_results.push_back(typed ? want : modeled);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: a done beat must match the oldest owed result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    list_out_t want;
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result beat: status %0d count %0d", result.status, result.count);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          mismatches++;
        end
        if (result.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, result.found);
          mismatches++;
        end
        if (result.read_word !== want.read_word) begin
          $error("read_word: expected %h, got %h", want.read_word, result.read_word);
          mismatches++;
        end
        if (result.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, result.count);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t row;
    list_in_t  it;
    int        k;
    int        n;
    int        phase;
    int        idle_pct;

    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    list_len   = 0;
    growing    = 1'b1;
    mismatches = 0;

    //       cmd               pos    word           reps typed status      fnd rd            cnt
    // empty list: every remove says empty, read/insert past end say bad index
    add_row(CMD_READ,          4'd0,  32'h0,         1,   1,    ST_BADIDX,   0, 32'h0,         5'd0);
    add_row(CMD_REMOVE_END,    4'd0,  32'h0,         1,   1,    ST_EMPTY,    0, 32'h0,         5'd0);
    add_row(CMD_REMOVE_FRONT,  4'd0,  32'h0,         1,   1,    ST_EMPTY,    0, 32'h0,         5'd0);
    add_row(CMD_REMOVE_AT,     4'd0,  32'h0,         1,   1,    ST_EMPTY,    0, 32'h0,         5'd0);
    add_row(CMD_REMOVE_VALUE,  4'd0,  32'h0,         1,   1,    ST_EMPTY,    0, 32'h0,         5'd0);
    add_row(CMD_SEARCH,        4'd0,  32'h0,         1,   1,    ST_NOTFOUND, 0, 32'h0,         5'd0);
    add_row(CMD_INSERT_AT,     4'd1,  32'h0,         1,   1,    ST_BADIDX,   0, 32'h0,         5'd0);
    // build [0, ffffffff, a5a5a5a5]
    add_row(CMD_INSERT_AT,     4'd0,  32'hFFFF_FFFF, 1,   1,    ST_OK,       0, 32'h0,         5'd1);
    add_row(CMD_INSERT_FRONT,  4'd0,  32'h0,         1,   1,    ST_OK,       0, 32'h0,         5'd2);
    add_row(CMD_INSERT_END,    4'd0,  32'hA5A5_A5A5, 1,   1,    ST_OK,       0, 32'h0,         5'd3);
    add_row(CMD_WRITE,         4'd15, 32'h1,         1,   1,    ST_BADIDX,   0, 32'h0,         5'd3);
    add_row(CMD_READ,          4'd1,  32'h0,         1,   1,    ST_OK,       0, 32'hFFFF_FFFF, 5'd3);
    add_row(CMD_SEARCH,        4'd0,  32'hFFFF_FFFF, 1,   1,    ST_OK,       1, 32'h0,         5'd3);
    add_row(CMD_REMOVE_VALUE,  4'd0,  32'h1234_5678, 1,   1,    ST_NOTFOUND, 0, 32'h0,         5'd3);
    add_row(CMD_WRITE,         4'd2,  32'h5A5A_5A5A, 1,   1,    ST_OK,       0, 32'h0,         5'd3);
    // spare code with all input bits high is a no-op
    add_row(CMD_SPARE,         4'd15, 32'hFFFF_FFFF, 1,   1,    ST_OK,       0, 32'h0,         5'd3);
    // insert at index == count appends; then fill with duplicates
    add_row(CMD_INSERT_AT,     4'd3,  32'h0000_00C3, 1,   1,    ST_OK,       0, 32'h0,         5'd4);
    add_row(CMD_INSERT_END,    4'd0,  32'h0000_00C3, 12,  0,    ST_OK,       0, 32'h0,         5'd0);
    // full list: full wins over the index check
    add_row(CMD_INSERT_FRONT,  4'd0,  32'h1,         1,   1,    ST_FULL,     0, 32'h0,         5'd16);
    add_row(CMD_INSERT_AT,     4'd15, 32'h1,         1,   1,    ST_FULL,     0, 32'h0,         5'd16);
    add_row(CMD_REMOVE_VALUE,  4'd0,  32'h0000_00C3, 1,   1,    ST_OK,       1, 32'h0,         5'd15);
    add_row(CMD_READ,          4'd15, 32'h0,         1,   1,    ST_BADIDX,   0, 32'h0,         5'd15);
    add_row(CMD_SEARCH,        4'd0,  32'h5A5A_5A5A, 1,   1,    ST_OK,       1, 32'h0,         5'd15);
    add_row(CMD_REMOVE_AT,     4'd14, 32'h0,         1,   0,    ST_OK,       0, 32'h0,         5'd0);
    add_row(CMD_REMOVE_FRONT,  4'd0,  32'h0,         1,   0,    ST_OK,       0, 32'h0,         5'd0);
    add_row(CMD_READ,          4'd0,  32'h0,         1,   0,    ST_OK,       0, 32'h0,         5'd0);

    // hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[k]) begin
      row         = stim_rows[k];
      it.cmd      = row.cmd;
      it.position = row.position;
      it.word     = row.word;
      for (n = 0; n < row.reps; n++) issue(it, 25, row.typed, row.want);
    end

    // random: sender idles 25%, then 68%, then never
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 25 : (phase == 1) ? 68 : 0;
      for (k = 0; k < RANDOM_BEATS; k++) issue(pick_random_cmd(), idle_pct, 1'b0, '0);
    end

    @(negedge clk);
    start <= 1'b0;

    // wait out owed results, then a tail to catch stray beats
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && owed_results.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
